// File: src/ubl_pkg.sv
// Shared types and constants for the bitfield layout block.
`default_nettype none
package ubl_pkg;

  localparam int OFFSET_WIDTH_DEF = 16;

  // Item commands.
  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_FINALIZE = 2'd1;
  localparam logic [1:0] CMD_BEGIN    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENDIAN    = 2'd0;
  localparam logic [1:0] CFG_MAX_ALIGN = 2'd1;

  localparam logic [4:0] MAX_ALIGN_RST = 5'd8;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_WIDE  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  field_bits;
    logic [3:0]  base_bytes;
    logic [4:0]  base_align;
    logic [15:0] start_offset;
    logic [4:0]  start_align;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] field_offset;
    logic [3:0]  unit_size;
    logic [5:0]  bit_pos;
    logic [15:0] struct_offset;
    logic [4:0]  struct_align;
  } out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [4:0] value;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ALIGN,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

// File: src/ubl_chan_if.sv
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface ubl_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/unit_bitfield_layout.sv
// Bitfield layout engine: places one bitfield per push item using the storage-unit rule.
//
// Channels: item (sink) takes push, finalize and begin commands; result (source)
// returns one beat per item; cfg (sink, always ready) writes the bit order select
// (index 0) and max_alignment (index 1). The user must write cfg only while the
// block is idle; the block itself does not enforce this.
// Sequencing: a push that changes the declared type size runs the offset through a
// remainder unit that retires four dividend bits per cycle, through the prep,
// divide, align and final steps; every other item goes from prep to the final step.
// Throughput: one item at a time; item.ready is high only while the sequencer is
// idle, so a new item is taken only after the last one leaves the final step.
// The result sits in an output register; if the receiver stalls, a finished item
// waits in the final step until the register frees, and no new item is taken.
// Reset (synchronous, active high) clears the running offset, the open unit and
// the structure alignment, selects little endian bit order, sets max_alignment
// to 8, and empties the output register.
`default_nettype none
module unit_bitfield_layout #(
  parameter int OFFSET_WIDTH = ubl_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ubl_chan_if.sink   cfg,
  ubl_chan_if.sink   item,
  ubl_chan_if.source result
);

  localparam int OW    = OFFSET_WIDTH;
  localparam int NSTEP = (OW + 3) / 4;
  localparam int DW    = NSTEP * 4;
  localparam int CW    = $clog2(NSTEP);
  localparam logic [OW-1:0] OFF_MAX = {OW{1'b1}};

  ubl_pkg::state_t state, state_next;

  logic           big_endian;
  logic [4:0]     max_alignment;

  logic [OW-1:0]  byte_offset, byte_offset_next;
  logic [6:0]     bits_used, bits_used_next;
  logic [3:0]     unit_bytes, unit_bytes_next;
  logic [4:0]     unit_align, unit_align_next;
  logic [4:0]     max_seen_align, max_seen_align_next;
  logic           ovf, ovf_next;

  ubl_pkg::in_t   cur, cur_next;
  logic [DW-1:0]  dvd, dvd_next;
  logic [4:0]     rem, rem_next;
  logic [CW-1:0]  div_cnt, div_cnt_next;

  ubl_pkg::out_t  res, res_next;
  logic           res_valid, res_valid_next;

  // Combinational working values.
  logic [3:0]     tsize_c;
  logic [4:0]     al_c;
  logic [OW-1:0]  off_c;
  logic [OW:0]    sum_c;
  logic [5:0]     t_c;
  logic [4:0]     r_c;
  logic [DW-1:0]  d_c;
  logic [6:0]     cap_c;
  logic [6:0]     bu_c;
  logic           ovf_c;
  logic           placed_c;
  logic           too_wide_c;
  logic [5:0]     pos_c;
  logic           slot_free;

  function automatic logic [OW:0] add_off(logic [OW-1:0] base, logic [4:0] n);
    return {1'b0, base} + {{(OW - 4){1'b0}}, n};
  endfunction

  assign cfg.ready    = 1'b1;
  assign item.ready   = (state == ubl_pkg::ST_IDLE);
  assign result.valid = res_valid;
  assign result.data  = res;

  assign tsize_c   = (cur.base_bytes > 4'd8) ? 4'd8 : cur.base_bytes;
  assign slot_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ubl_pkg::ST_IDLE;
      big_endian     <= 1'b0;
      max_alignment  <= ubl_pkg::MAX_ALIGN_RST;
      byte_offset    <= '0;
      bits_used      <= '0;
      unit_bytes     <= '0;
      unit_align     <= '0;
      max_seen_align <= '0;
      ovf            <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      byte_offset    <= byte_offset_next;
      bits_used      <= bits_used_next;
      unit_bytes     <= unit_bytes_next;
      unit_align     <= unit_align_next;
      max_seen_align <= max_seen_align_next;
      ovf            <= ovf_next;
      res_valid      <= res_valid_next;
      if (cfg.valid) begin
        unique case (cfg.data.index)
          ubl_pkg::CFG_ENDIAN:    big_endian    <= cfg.data.value[0];
          ubl_pkg::CFG_MAX_ALIGN: max_alignment <= cfg.data.value;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    dvd     <= dvd_next;
    rem     <= rem_next;
    div_cnt <= div_cnt_next;
    res     <= res_next;
  end

  always_comb begin
    state_next          = state;
    byte_offset_next    = byte_offset;
    bits_used_next      = bits_used;
    unit_bytes_next     = unit_bytes;
    unit_align_next     = unit_align;
    max_seen_align_next = max_seen_align;
    ovf_next            = ovf;
    cur_next            = cur;
    dvd_next            = dvd;
    rem_next            = rem;
    div_cnt_next        = div_cnt;
    res_next            = res;
    res_valid_next      = res_valid && !result.ready;

    al_c       = (cur.base_align < max_alignment) ? cur.base_align : max_alignment;
    off_c      = byte_offset;
    sum_c      = '0;
    t_c        = '0;
    r_c        = rem;
    d_c        = dvd;
    cap_c      = {unit_bytes, 3'b000};
    bu_c       = bits_used;
    ovf_c      = ovf;
    placed_c   = 1'b0;
    too_wide_c = 1'b0;
    pos_c      = '0;

    unique case (state)
      ubl_pkg::ST_IDLE: begin
        if (item.valid) begin
          cur_next   = item.data;
          ovf_next   = 1'b0;
          state_next = ubl_pkg::ST_PREP;
        end
      end

      ubl_pkg::ST_PREP: begin
        // A push with a new type size closes the open unit and then aligns.
        if (cur.cmd == ubl_pkg::CMD_PUSH && unit_bytes != tsize_c) begin
          if (al_c == 5'd0) begin
            al_c = 5'd1;
          end
          unit_align_next = al_c;
          if (al_c > max_seen_align) begin
            max_seen_align_next = al_c;
          end
          if (bits_used != 7'd0) begin
            sum_c = add_off(byte_offset, {1'b0, unit_bytes});
            if (sum_c[OW]) begin
              off_c    = OFF_MAX;
              ovf_next = 1'b1;
            end else begin
              off_c = sum_c[OW-1:0];
            end
            bits_used_next = '0;
          end
          byte_offset_next = off_c;
          dvd_next         = DW'(off_c);
          rem_next         = '0;
          div_cnt_next     = CW'(NSTEP - 1);
          state_next       = ubl_pkg::ST_DIV;
        end else begin
          state_next = ubl_pkg::ST_FIN;
        end
      end

      ubl_pkg::ST_DIV: begin
        // Restoring remainder, four dividend bits per cycle, MSB first.
        for (int k = 0; k < 4; k++) begin
          t_c = {r_c, d_c[DW-1]};
          d_c = d_c << 1;
          if (t_c >= {1'b0, unit_align}) begin
            r_c = 5'(t_c - {1'b0, unit_align});
          end else begin
            r_c = t_c[4:0];
          end
        end
        dvd_next = d_c;
        rem_next = r_c;
        if (div_cnt == '0) begin
          state_next = ubl_pkg::ST_ALIGN;
        end else begin
          div_cnt_next = div_cnt - 1'b1;
        end
      end

      ubl_pkg::ST_ALIGN: begin
        if (rem != 5'd0) begin
          sum_c = add_off(byte_offset, 5'(unit_align - rem));
          if (sum_c[OW]) begin
            byte_offset_next = OFF_MAX;
            ovf_next         = 1'b1;
          end else begin
            byte_offset_next = sum_c[OW-1:0];
          end
          bits_used_next = '0;
        end
        unit_bytes_next = tsize_c;
        state_next      = ubl_pkg::ST_FIN;
      end

      ubl_pkg::ST_FIN: begin
        if (slot_free) begin
          case (cur.cmd)
            ubl_pkg::CMD_BEGIN: begin
              off_c               = OW'(cur.start_offset);
              max_seen_align_next = cur.start_align;
              bits_used_next      = '0;
              unit_bytes_next     = '0;
              unit_align_next     = '0;
            end
            ubl_pkg::CMD_FINALIZE: begin
              if (bits_used != 7'd0) begin
                sum_c = add_off(byte_offset, {1'b0, unit_bytes});
                if (sum_c[OW]) begin
                  off_c = OFF_MAX;
                  ovf_c = 1'b1;
                end else begin
                  off_c = sum_c[OW-1:0];
                end
                bits_used_next = '0;
              end
            end
            ubl_pkg::CMD_PUSH: begin
              if (cur.field_bits == 7'd0) begin
                if (bits_used != 7'd0) begin
                  sum_c = add_off(byte_offset, {1'b0, unit_bytes});
                  if (sum_c[OW]) begin
                    off_c = OFF_MAX;
                    ovf_c = 1'b1;
                  end else begin
                    off_c = sum_c[OW-1:0];
                  end
                  bits_used_next = '0;
                end
              end else if (cur.field_bits > cap_c) begin
                too_wide_c = 1'b1;
              end else begin
                // The field does not fit the rest of the unit: open the next one.
                if (cur.field_bits > cap_c - bits_used) begin
                  sum_c = add_off(byte_offset, {1'b0, unit_bytes});
                  if (sum_c[OW]) begin
                    off_c = OFF_MAX;
                    ovf_c = 1'b1;
                  end else begin
                    off_c = sum_c[OW-1:0];
                  end
                  bu_c = '0;
                end
                if (big_endian) begin
                  pos_c = 6'(cap_c - bu_c - cur.field_bits);
                end else begin
                  pos_c = bu_c[5:0];
                end
                bits_used_next = bu_c + cur.field_bits;
                placed_c       = 1'b1;
              end
            end
            default: ;
          endcase

          byte_offset_next = off_c;
          if (ovf_c) begin
            res_next.status = ubl_pkg::STAT_OVERFLOW;
          end else if (too_wide_c) begin
            res_next.status = ubl_pkg::STAT_TOO_WIDE;
          end else begin
            res_next.status = ubl_pkg::STAT_OK;
          end
          res_next.field_offset  = 16'(off_c);
          res_next.unit_size     = placed_c ? unit_bytes : 4'd0;
          res_next.bit_pos       = placed_c ? pos_c : 6'd0;
          res_next.struct_offset = 16'(off_c);
          res_next.struct_align  = max_seen_align_next;
          res_valid_next         = 1'b1;
          state_next             = ubl_pkg::ST_IDLE;
        end
      end

      default: state_next = ubl_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
